// ===== hdl/tdsmc_pkg.sv =====
// Shared types and constants for the TDS median conductivity converter.
// No dependencies; imported by the mul/div unit and the top level.
`timescale 1ns / 1ps

package tdsmc_pkg;

  // Default geometry
  localparam int DEF_WINDOW_DEPTH = 32;
  localparam int DEF_SAMPLE_BITS  = 16;

  // Register reset values
  localparam logic [12:0]        RST_VREF     = 13'd3300;
  localparam logic [15:0]        RST_FS       = 16'd4095;
  localparam logic signed [14:0] RST_TEMP     = 15'sd2500;
  localparam logic [15:0]        RST_COEFF    = 16'd1311;
  localparam logic [23:0]        RST_SCALE    = 24'd32768;
  localparam logic [31:0]        CAL_ONE      = 32'd65536;

  // Fixed-point constants
  localparam logic [63:0] POLY_A   = 64'd8743813;
  localparam logic [63:0] POLY_B   = 64'd16768041;
  localparam logic [63:0] POLY_C   = 64'd56189911;
  localparam logic [63:0] CAP62    = 64'h4000_0000_0000_0000;
  localparam logic [22:0] CV_MAX   = 23'h7F_FFFF;
  localparam logic [19:0] V_MAX    = 20'hF_FFFF;
  localparam logic [63:0] TINY_Q16 = 64'd6;

  // Divide by 100 as multiply and shift: ceil(2^37 / 100), exact below 2^32
  localparam logic [63:0] RECIP_100    = 64'd1374389535;
  localparam int          RECIP_100_SH = 37;

  // Mul/div unit geometry
  localparam int MD_W   = 64;
  localparam int MD_P_W = 96;

  typedef enum logic [1:0] {
    FUNC_PUSH      = 2'd0,
    FUNC_MEASURE   = 2'd1,
    FUNC_CALIBRATE = 2'd2,
    FUNC_SET_CAL   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_VREF       = 3'd0,
    CFG_FULL_SCALE = 3'd1,
    CFG_TEMP       = 3'd2,
    CFG_COEFF      = 3'd3,
    CFG_SCALE      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

endpackage

// ===== hdl/tdsmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tdsmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/tdsmc_muldiv.sv =====
// Shared iterative arithmetic unit: 64x32 shift-add multiply, 64/64 restoring divide.
// Depends on tdsmc_pkg.
`timescale 1ns / 1ps

module tdsmc_muldiv
  import tdsmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md_req_t           req_i,
  input  logic [MD_W-1:0]   a_i,    // multiplicand or dividend
  input  logic [MD_W-1:0]   b_i,    // multiplier (low 32 bits) or divisor
  output logic              done_o,
  output logic [MD_P_W-1:0] res_o   // product, or quotient in the low bits
);

  logic              busy_q;
  md_op_e            op_q;
  logic [6:0]        cnt_q;
  logic [MD_P_W-1:0] acc_q;
  logic [MD_P_W-1:0] x_q;
  logic [MD_W-1:0]   y_q;
  logic              done_q;

  logic [MD_W:0]     rem_s;
  logic              rem_ge;
  logic [MD_W:0]     rem_sub;
  logic              last;

  // One divide step: shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_s   = {acc_q[MD_W-1:0], y_q[MD_W-1]};
    rem_ge  = rem_s >= {1'b0, x_q[MD_W-1:0]};
    rem_sub = rem_s - {1'b0, x_q[MD_W-1:0]};
    last    = (op_q == MD_MUL) ? (cnt_q == 7'd31) : (cnt_q == 7'd63);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
        acc_q  <= '0;
        if (req_i.op == MD_MUL) begin
          x_q <= {32'd0, a_i};
          y_q <= {32'd0, b_i[31:0]};
        end else begin
          x_q <= {32'd0, b_i};
          y_q <= a_i;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (op_q == MD_MUL) begin
          if (y_q[0]) begin
            acc_q <= acc_q + x_q;
          end
          x_q <= {x_q[MD_P_W-2:0], 1'b0};
          y_q <= {1'b0, y_q[MD_W-1:1]};
        end else begin
          acc_q <= {31'd0, rem_ge ? rem_sub : rem_s};
          y_q   <= {y_q[MD_W-2:0], rem_ge};
        end
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == MD_MUL) ? acc_q : {32'd0, y_q};

endmodule

// ===== hdl/tds_median_conductivity_converter_top.sv =====
// TDS converter top: sample window RAM, radix median select, fixed-point sequencer.
// Depends on tdsmc_pkg, tdsmc_ram and tdsmc_muldiv.
// Push and set-factor beats complete at accept, and the block stays idle. A measure or
// calibrate runs the median sweep, then the mul/div steps, before its result is loaded;
// a zero full scale skips the voltage divide, and output stalls delay the load.
// After reset a clearing pass zeroes the window; no input is taken meanwhile.
`timescale 1ns / 1ps

module tds_median_conductivity_converter_top
  import tdsmc_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // raw_sample[15:0], known_tds_q8, new_cal_q16
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // voltage_q16[19:0], tds_ppm_q8[31:0], zero pad
  output logic [1:0]  m_axis_tuser,   // success, reading_valid
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int BW   = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;
  localparam int K_HI = WINDOW_DEPTH / 2;
  localparam int K_LO = ((WINDOW_DEPTH % 2) == 0) ? (WINDOW_DEPTH / 2 - 1) : (WINDOW_DEPTH / 2);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MED, ST_V_ISS, ST_V_WAIT, ST_C_ISS, ST_C_WAIT,
    ST_CV_ISS, ST_CV_WAIT, ST_T1_WAIT, ST_T2_WAIT, ST_T3_WAIT, ST_SC_WAIT,
    ST_CAL_WAIT, ST_FAC_WAIT, ST_OUT
  } state_e;

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Configuration registers
  logic [12:0]        vref_q;
  logic [15:0]        fs_q;
  logic signed [14:0] temp_q;
  logic [15:0]        coeff_q;
  logic [23:0]        scale_q;

  // Block state
  state_e                 state_q;
  logic [AW-1:0]          wpos_q;
  logic [31:0]            cal_q;
  logic                   fresh_q;
  func_e                  func_q;
  logic [31:0]            known_q;

  // Median select
  logic [CW-1:0]          cnt_q;
  logic [BW-1:0]          bit_q;
  logic [SAMPLE_BITS-1:0] pfx_lo_q, pfx_hi_q;
  logic [CW-1:0]          k_lo_q, k_hi_q, c_lo_q, c_hi_q;

  // Datapath
  logic [19:0]            v_q;
  logic [24:0]            c_q;
  logic [22:0]            cv_q;
  logic                   neg_q;
  logic                   kneg_q;
  logic [63:0]            meas_q;
  logic                   ok_q;
  logic                   rv_q;

  // Mul/div request
  logic                   md_start_q;
  md_op_e                 md_op_q;
  logic [63:0]            md_a_q, md_b_q;
  md_req_t                md_req;
  logic                   md_done;
  logic [MD_P_W-1:0]      md_res;

  // Output register
  logic                   m_valid_q;
  logic [55:0]            m_data_q;
  logic [1:0]             m_user_q;

  // Window RAM
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  logic                   s_acc;
  func_e                  s_func;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_func        = func_e'(s_axis_tuser);

  assign ram_we    = (state_q == ST_CLEAR) || (s_acc && s_func == FUNC_PUSH);
  assign ram_waddr = (state_q == ST_CLEAR) ? cnt_q[AW-1:0] : wpos_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : s_axis_tdata[SAMPLE_BITS-1:0];

  tdsmc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign md_req = '{start: md_start_q, op: md_op_q};

  tdsmc_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a_q),
    .b_i    (md_b_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  // Radix select: count entries that match the prefix with the current bit low
  logic [SAMPLE_BITS-1:0] bmask;
  logic                   dv;
  logic [CW-1:0]          c_lo_nx, c_hi_nx;
  logic                   lo_one, hi_one;
  assign bmask   = {SAMPLE_BITS{1'b1}} << bit_q;
  assign dv      = (cnt_q != '0);
  assign c_lo_nx = c_lo_q + CW'(dv && (((ram_rdata ^ pfx_lo_q) & bmask) == '0));
  assign c_hi_nx = c_hi_q + CW'(dv && (((ram_rdata ^ pfx_hi_q) & bmask) == '0));
  assign lo_one  = (k_lo_q >= c_lo_nx);
  assign hi_one  = (k_hi_q >= c_hi_nx);

  // Voltage operands
  logic [SAMPLE_BITS:0]    med_sum;
  logic [SAMPLE_BITS+12:0] mv;
  logic [25:0]             den_v;
  logic [63:0]             v_num;
  assign med_sum = {1'b0, pfx_lo_q} + {1'b0, pfx_hi_q};
  assign mv      = med_sum[SAMPLE_BITS:1] * vref_q;
  assign den_v   = fs_q * 10'd1000;
  assign v_num   = (64'(mv) << 16) + 64'(den_v[25:1]);

  // Compensation term k*(T-25C), quotient by 100 from the reciprocal product
  logic signed [16:0] tdiff;
  logic signed [33:0] kt;
  logic [33:0]        kt_abs;
  logic signed [35:0] c_raw;
  logic [24:0]        c_nx;
  assign tdiff  = 17'(temp_q) - 17'sd2500;
  assign kt     = $signed({1'b0, coeff_q}) * tdiff;
  assign kt_abs = kt[33] ? (~kt + 34'd1) : kt;
  assign c_raw  = kneg_q ? (36'sd65536 - $signed({2'b00, md_res[RECIP_100_SH +: 34]}))
                         : (36'sd65536 + $signed({2'b00, md_res[RECIP_100_SH +: 34]}));
  assign c_nx   = (c_raw <= 36'sd6) ? 25'd65536 : c_raw[24:0];

  // Result shaping
  logic [22:0] cv_nx;
  logic [63:0] q16_sat, t1_v, t2_v, p_nx;
  assign cv_nx   = (md_res[63:0] > 64'(CV_MAX)) ? CV_MAX : md_res[22:0];
  assign q16_sat = (md_res[95:16] > {16'd0, CAP62}) ? CAP62 : md_res[79:16];
  assign t1_v    = md_res[79:16] - POLY_B;
  assign t2_v    = (neg_q ? (~md_res[79:16] + 64'd1) : md_res[79:16]) + POLY_C;
  assign p_nx    = neg_q ? 64'd0 : q16_sat;

  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q     <= RST_VREF;
      fs_q       <= RST_FS;
      temp_q     <= RST_TEMP;
      coeff_q    <= RST_COEFF;
      scale_q    <= RST_SCALE;
      state_q    <= ST_CLEAR;
      wpos_q     <= '0;
      cal_q      <= CAL_ONE;
      fresh_q    <= 1'b0;
      func_q     <= FUNC_PUSH;
      known_q    <= '0;
      cnt_q      <= '0;
      bit_q      <= '0;
      pfx_lo_q   <= '0;
      pfx_hi_q   <= '0;
      k_lo_q     <= '0;
      k_hi_q     <= '0;
      c_lo_q     <= '0;
      c_hi_q     <= '0;
      v_q        <= '0;
      c_q        <= '0;
      cv_q       <= '0;
      neg_q      <= 1'b0;
      kneg_q     <= 1'b0;
      meas_q     <= '0;
      ok_q       <= 1'b0;
      rv_q       <= 1'b0;
      md_start_q <= 1'b0;
      md_op_q    <= MD_MUL;
      md_a_q     <= '0;
      md_b_q     <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
    end else begin
      md_start_q <= 1'b0;
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // Register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_VREF:       vref_q  <= cfg_data_i[12:0];
          CFG_FULL_SCALE: fs_q    <= cfg_data_i[15:0];
          CFG_TEMP:       temp_q  <= $signed(cfg_data_i[14:0]);
          CFG_COEFF:      coeff_q <= cfg_data_i[15:0];
          CFG_SCALE:      scale_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        // Zero the window once after reset
        ST_CLEAR: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(WINDOW_DEPTH - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_acc) begin
            case (s_func)
              FUNC_PUSH: begin
                wpos_q  <= (wpos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
                fresh_q <= 1'b0;
              end
              FUNC_SET_CAL: begin
                cal_q <= (s_axis_tdata[79:48] == 32'd0) ? CAL_ONE : s_axis_tdata[79:48];
              end
              default: begin
                func_q   <= s_func;
                known_q  <= s_axis_tdata[47:16];
                cnt_q    <= '0;
                bit_q    <= BW'(SAMPLE_BITS - 1);
                pfx_lo_q <= '0;
                pfx_hi_q <= '0;
                k_lo_q   <= CW'(K_LO);
                k_hi_q   <= CW'(K_HI);
                c_lo_q   <= '0;
                c_hi_q   <= '0;
                state_q  <= ST_MED;
              end
            endcase
          end
        end

        // One window sweep per bit, both middle ranks at once
        ST_MED: begin
          c_lo_q <= c_lo_nx;
          c_hi_q <= c_hi_nx;
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == CW'(WINDOW_DEPTH)) begin
            cnt_q  <= '0;
            c_lo_q <= '0;
            c_hi_q <= '0;
            if (lo_one) begin
              pfx_lo_q[bit_q] <= 1'b1;
              k_lo_q          <= k_lo_q - c_lo_nx;
            end
            if (hi_one) begin
              pfx_hi_q[bit_q] <= 1'b1;
              k_hi_q          <= k_hi_q - c_hi_nx;
            end
            if (bit_q == '0) begin
              state_q <= ST_V_ISS;
            end else begin
              bit_q <= bit_q - BW'(1);
            end
          end
        end

        // Median to volts
        ST_V_ISS: begin
          if (fs_q == 16'd0) begin
            v_q     <= '0;
            state_q <= ST_C_ISS;
          end else begin
            md_start_q <= 1'b1;
            md_op_q    <= MD_DIV;
            md_a_q     <= v_num;
            md_b_q     <= 64'(den_v);
            state_q    <= ST_V_WAIT;
          end
        end

        ST_V_WAIT: begin
          if (md_done) begin
            v_q     <= (md_res[63:0] > 64'(V_MAX)) ? V_MAX : md_res[19:0];
            state_q <= ST_C_ISS;
          end
        end

        // Temperature compensation term, |k*dT| / 100 by reciprocal multiply
        ST_C_ISS: begin
          if (func_q == FUNC_CALIBRATE) begin
            c_q     <= 25'd65536;
            state_q <= ST_CV_ISS;
          end else begin
            kneg_q     <= kt[33];
            md_start_q <= 1'b1;
            md_op_q    <= MD_MUL;
            md_a_q     <= 64'(kt_abs);
            md_b_q     <= RECIP_100;
            state_q    <= ST_C_WAIT;
          end
        end

        ST_C_WAIT: begin
          if (md_done) begin
            c_q     <= c_nx;
            state_q <= ST_CV_ISS;
          end
        end

        ST_CV_ISS: begin
          md_start_q <= 1'b1;
          md_op_q    <= MD_DIV;
          md_a_q     <= {28'd0, v_q, 16'd0};
          md_b_q     <= 64'(c_q);
          state_q    <= ST_CV_WAIT;
        end

        // Compensated voltage, then Horner steps
        ST_CV_WAIT: begin
          if (md_done) begin
            cv_q       <= cv_nx;
            md_start_q <= 1'b1;
            md_op_q    <= MD_MUL;
            md_a_q     <= POLY_A;
            md_b_q     <= 64'(cv_nx);
            state_q    <= ST_T1_WAIT;
          end
        end

        ST_T1_WAIT: begin
          if (md_done) begin
            neg_q      <= t1_v[63];
            md_start_q <= 1'b1;
            md_op_q    <= MD_MUL;
            md_a_q     <= abs64(t1_v);
            md_b_q     <= 64'(cv_q);
            state_q    <= ST_T2_WAIT;
          end
        end

        ST_T2_WAIT: begin
          if (md_done) begin
            neg_q      <= t2_v[63];
            md_start_q <= 1'b1;
            md_op_q    <= MD_MUL;
            md_a_q     <= abs64(t2_v);
            md_b_q     <= 64'(cv_q);
            state_q    <= ST_T3_WAIT;
          end
        end

        // Negative polynomial clamps to zero, then TDS factor
        ST_T3_WAIT: begin
          if (md_done) begin
            md_start_q <= 1'b1;
            md_op_q    <= MD_MUL;
            md_a_q     <= p_nx;
            md_b_q     <= 64'(scale_q);
            state_q    <= ST_SC_WAIT;
          end
        end

        ST_SC_WAIT: begin
          if (md_done) begin
            if (func_q == FUNC_MEASURE) begin
              md_start_q <= 1'b1;
              md_op_q    <= MD_MUL;
              md_a_q     <= q16_sat;
              md_b_q     <= 64'(cal_q);
              state_q    <= ST_CAL_WAIT;
            end else begin
              meas_q <= q16_sat;
              if (known_q != 32'd0 && q16_sat > TINY_Q16) begin
                md_start_q <= 1'b1;
                md_op_q    <= MD_DIV;
                md_a_q     <= {8'd0, known_q, 24'd0};
                md_b_q     <= q16_sat;
                state_q    <= ST_FAC_WAIT;
              end else begin
                ok_q    <= 1'b0;
                rv_q    <= fresh_q;
                state_q <= ST_OUT;
              end
            end
          end
        end

        ST_CAL_WAIT: begin
          if (md_done) begin
            meas_q  <= q16_sat;
            ok_q    <= 1'b1;
            rv_q    <= fresh_q;
            fresh_q <= 1'b1;
            state_q <= ST_OUT;
          end
        end

        // New calibration factor from the reference solution
        ST_FAC_WAIT: begin
          if (md_done) begin
            if (md_res[63:0] != 64'd0) begin
              cal_q   <= (md_res[63:32] != 32'd0) ? 32'hFFFF_FFFF : md_res[31:0];
              fresh_q <= 1'b0;
              ok_q    <= 1'b1;
              rv_q    <= 1'b0;
            end else begin
              ok_q <= 1'b0;
              rv_q <= fresh_q;
            end
            state_q <= ST_OUT;
          end
        end

        // Load the output beat once the register is free
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'd0,
                          (meas_q[63:40] != 24'd0) ? 32'hFFFF_FFFF : meas_q[39:8],
                          v_q};
            m_user_q  <= {rv_q, ok_q};
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
